// ===== hw/rtl/cbcb_pkg.sv =====
package cbcb_pkg;

	localparam int MAX_DIM   = 4096;
	localparam int COORD_W   = $clog2(MAX_DIM);
	localparam int DIM_W     = COORD_W + 1;
	localparam int CHAN_W    = 8;
	localparam int PIX_W     = 4 * CHAN_W;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 2'd2;

	localparam logic [CHAN_W-1:0] OPAQUE = 8'hFF;

	typedef logic [COORD_W-1:0] coord_t;

	typedef enum logic [1:0] {
		ST_CROP      = 2'd0,
		ST_ALL_CLEAR = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	// last valid index for a dimension; zero acts as one, oversize saturates
	function automatic coord_t dim_last(input logic [DIM_W-1:0] v);
		coord_t r;
		if (v == '0) begin
			r = '0;
		end else if (v > DIM_W'(MAX_DIM)) begin
			r = COORD_W'(MAX_DIM - 1);
		end else begin
			r = COORD_W'(v - DIM_W'(1));
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/cbcb_pixel_if.sv =====
interface cbcb_pixel_if;
	logic                         valid;
	logic                         ready;
	logic [cbcb_pkg::CHAN_W-1:0]  red;
	logic [cbcb_pkg::CHAN_W-1:0]  green;
	logic [cbcb_pkg::CHAN_W-1:0]  blue;
	logic [cbcb_pkg::CHAN_W-1:0]  alpha;

	modport source (output valid, red, green, blue, alpha, input ready);
	modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

// ===== hw/rtl/cbcb_bounds_if.sv =====
interface cbcb_bounds_if;
	logic                 valid;
	logic                 ready;
	cbcb_pkg::status_t    status;
	cbcb_pkg::coord_t     top_row;
	cbcb_pkg::coord_t     bottom_row;
	cbcb_pkg::coord_t     left_col;
	cbcb_pkg::coord_t     right_col;

	modport source (output valid, status, top_row, bottom_row, left_col, right_col,
		input ready);
	modport sink   (input valid, status, top_row, bottom_row, left_col, right_col,
		output ready);
endinterface

// ===== hw/rtl/clear_border_crop_bounds.sv =====
// Content bounding box for auto-crop. Pixels arrive in raster order on the
// pixel channel, one request per pixel; the first pixel of each frame sets the
// clear color (alpha compared only when has_alpha is 1). After the frame's
// last pixel one request leaves on the bounds channel with a status (crop,
// all clear, or content fills the frame) and the top/bottom/left/right bounds.
// One pixel is accepted every clock unless the stall below holds the input; each
// pixel is captured in an input register and then folded into the bounds, and
// the result register is loaded when the last pixel is folded in. The only
// stall is a last pixel arriving while the previous result is still held in
// the output register. Any configuration write to a defined register aborts
// the frame in progress; write configuration only while the block is idle.
module clear_border_crop_bounds (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [cbcb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cbcb_pkg::DIM_W-1:0]    cfg_wdata,
	cbcb_pixel_if.sink                    pixel,
	cbcb_bounds_if.source                 bounds
);
	import cbcb_pkg::*;

	coord_t  width_last_q;
	coord_t  height_last_q;
	logic    has_alpha_q;

	logic              valid_s1;
	logic [PIX_W-1:0]  pix_s1;

	logic [PIX_W-1:0]  clear_q;
	coord_t            col_q;
	coord_t            row_q;
	coord_t            min_col_q;
	coord_t            max_col_q;
	coord_t            min_row_q;
	coord_t            max_row_q;
	logic              seen_q;

	logic              out_valid_q;
	status_t           status_q;
	coord_t            top_q;
	coord_t            bottom_q;
	coord_t            left_q;
	coord_t            right_q;

	logic              cfg_hit;
	logic              first_pix;
	logic              last_col;
	logic              is_last;
	logic              is_content;
	logic              out_space;
	logic              advance;
	logic              in_take;
	coord_t            n_min_col;
	coord_t            n_max_col;
	coord_t            n_min_row;
	coord_t            n_max_row;
	logic              n_seen;
	status_t           n_status;
	logic [CHAN_W-1:0] alpha_eff;

	always_comb begin
		unique case (cfg_index) inside
			REG_WIDTH, REG_HEIGHT, REG_ALPHA: cfg_hit = cfg_wr_en;
			default:                          cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_last_q  <= '0;
			height_last_q <= '0;
			has_alpha_q   <= 1'b1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_WIDTH:  width_last_q  <= dim_last(cfg_wdata);
				REG_HEIGHT: height_last_q <= dim_last(cfg_wdata);
				REG_ALPHA:  has_alpha_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign first_pix = (col_q == '0) && (row_q == '0);
	assign last_col  = col_q >= width_last_q;
	assign is_last   = last_col && (row_q >= height_last_q);
	assign is_content = !first_pix && (pix_s1 != clear_q);

	assign out_space   = !out_valid_q || bounds.ready;
	assign advance     = valid_s1 && (!is_last || out_space);
	assign pixel.ready = !valid_s1 || advance;
	assign in_take     = pixel.valid && pixel.ready;
	assign alpha_eff   = has_alpha_q ? pixel.alpha : OPAQUE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel.ready) begin
			valid_s1 <= pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			pix_s1 <= {alpha_eff, pixel.blue, pixel.green, pixel.red};
		end
	end

	always_comb begin
		n_min_col = min_col_q;
		n_max_col = max_col_q;
		n_min_row = min_row_q;
		n_max_row = max_row_q;
		n_seen    = seen_q;
		if (is_content) begin
			n_seen = 1'b1;
			if (!seen_q) begin
				n_min_col = col_q;
				n_max_col = col_q;
				n_min_row = row_q;
				n_max_row = row_q;
			end else begin
				if (col_q < min_col_q) n_min_col = col_q;
				if (col_q > max_col_q) n_max_col = col_q;
				if (row_q < min_row_q) n_min_row = row_q;
				if (row_q > max_row_q) n_max_row = row_q;
			end
		end
		if (!n_seen) begin
			n_status = ST_ALL_CLEAR;
		end else if (n_min_row == '0 && n_max_row == height_last_q &&
				n_min_col == '0 && n_max_col == width_last_q) begin
			n_status = ST_FULL;
		end else begin
			n_status = ST_CROP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q   <= '0;
			col_q     <= '0;
			row_q     <= '0;
			min_col_q <= '0;
			max_col_q <= '0;
			min_row_q <= '0;
			max_row_q <= '0;
			seen_q    <= 1'b0;
		end else if (cfg_hit || (advance && is_last)) begin
			col_q     <= '0;
			row_q     <= '0;
			min_col_q <= '0;
			max_col_q <= '0;
			min_row_q <= '0;
			max_row_q <= '0;
			seen_q    <= 1'b0;
			if (advance && first_pix) begin
				clear_q <= pix_s1;
			end
		end else if (advance) begin
			if (first_pix) begin
				clear_q <= pix_s1;
			end
			min_col_q <= n_min_col;
			max_col_q <= n_max_col;
			min_row_q <= n_min_row;
			max_row_q <= n_max_row;
			seen_q    <= n_seen;
			if (last_col) begin
				col_q <= '0;
				row_q <= row_q + COORD_W'(1);
			end else begin
				col_q <= col_q + COORD_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && is_last) begin
			out_valid_q <= 1'b1;
		end else if (bounds.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_last) begin
			status_q <= n_status;
			if (n_seen) begin
				top_q    <= n_min_row;
				bottom_q <= n_max_row;
				left_q   <= n_min_col;
				right_q  <= n_max_col;
			end else begin
				top_q    <= '0;
				bottom_q <= '0;
				left_q   <= '0;
				right_q  <= '0;
			end
		end
	end

	assign bounds.valid      = out_valid_q;
	assign bounds.status     = status_q;
	assign bounds.top_row    = top_q;
	assign bounds.bottom_row = bottom_q;
	assign bounds.left_col   = left_q;
	assign bounds.right_col  = right_q;

`ifndef SYNTHESIS
	a_unseen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!seen_q |-> (min_col_q == '0 && max_col_q == '0 &&
			min_row_q == '0 && max_row_q == '0))
		else $error("bounds nonzero before any content");

	a_bounds_order: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q |-> (min_col_q <= max_col_q && min_row_q <= max_row_q))
		else $error("bounds out of order");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= width_last_q && row_q <= height_last_q))
		else $error("position past frame");

	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == ST_ALL_CLEAR) |->
			(top_q == '0 && bottom_q == '0 && left_q == '0 && right_q == '0))
		else $error("all-clear result carries bounds");
`endif

endmodule

// ===== verif/testbench.sv =====
module testbench;
	import cbcb_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

	typedef struct {
		status_t status;
		coord_t  top_row;
		coord_t  bottom_row;
		coord_t  left_col;
		coord_t  right_col;
	} crop_box_t;

	typedef enum {FR_CLEAR, FR_NOISE, FR_BOX, FR_BORDER, FR_ALPHA} scene_t;

	// bounds predictor plus the queue of boxes still owed by the block
	class crop_predictor;
		logic [DIM_W-1:0] width_reg;
		logic [DIM_W-1:0] height_reg;
		bit               alpha_on;
		logic [PIX_W-1:0] clear_px;
		int               col;
		int               row;
		int               lo_col;
		int               hi_col;
		int               lo_row;
		int               hi_row;
		bit               seen;
		crop_box_t        owed_boxes[$];
		int               errors;

		function void restart();
			col = 0;
			row = 0;
			lo_col = 0;
			hi_col = 0;
			lo_row = 0;
			hi_row = 0;
			seen = 0;
		endfunction

		function void power_on();
			width_reg = 1;
			height_reg = 1;
			alpha_on = 1;
			clear_px = '0;
			errors = 0;
			restart();
		endfunction

		function int span(logic [DIM_W-1:0] v);
			if (v == 0) return 1;
			if (v > MAX_DIM) return MAX_DIM;
			return int'(v);
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] v);
			case (idx)
				REG_WIDTH: width_reg = v;
				REG_HEIGHT: height_reg = v;
				REG_ALPHA: alpha_on = v[0];
				default: return;
			endcase
			restart();
		endfunction

		function void take_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
			int               w;
			int               h;
			logic [PIX_W-1:0] px;
			bit               end_col;
			bit               end_row;
			crop_box_t        box;
			w = span(width_reg);
			h = span(height_reg);
			px = {alpha_on ? a : OPAQUE, b, g, r};
			end_col = col >= w - 1;
			end_row = row >= h - 1;
			if (col == 0 && row == 0) clear_px = px;
			if (px != clear_px) begin
				if (!seen) begin
					lo_col = col;
					hi_col = col;
					lo_row = row;
					hi_row = row;
					seen = 1;
				end else begin
					if (col < lo_col) lo_col = col;
					if (col > hi_col) hi_col = col;
					if (row < lo_row) lo_row = row;
					if (row > hi_row) hi_row = row;
				end
			end
			if (end_col && end_row) begin
				if (!seen) begin
					box.status = ST_ALL_CLEAR;
					box.top_row = '0;
					box.bottom_row = '0;
					box.left_col = '0;
					box.right_col = '0;
				end else begin
					if (lo_row == 0 && hi_row == h - 1 && lo_col == 0 && hi_col == w - 1)
						box.status = ST_FULL;
					else
						box.status = ST_CROP;
					box.top_row = coord_t'(lo_row);
					box.bottom_row = coord_t'(hi_row);
					box.left_col = coord_t'(lo_col);
					box.right_col = coord_t'(hi_col);
				end
				owed_boxes = {owed_boxes, box};
				restart();
			end else if (end_col) begin
				col = 0;
				row = row + 1;
			end else begin
				col = col + 1;
			end
		endfunction

		function void check_box(status_t st, coord_t t, coord_t bt, coord_t l, coord_t rt);
			crop_box_t want;
			if (owed_boxes.size() == 0) begin
				$error("bounds request with no frame pending");
				errors++;
				return;
			end
			want = owed_boxes.pop_front();
			if (st !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, st);
				errors++;
			end
			if (t !== want.top_row) begin
				$error("top_row: expected %0d, actual %0d", want.top_row, t);
				errors++;
			end
			if (bt !== want.bottom_row) begin
				$error("bottom_row: expected %0d, actual %0d", want.bottom_row, bt);
				errors++;
			end
			if (l !== want.left_col) begin
				$error("left_col: expected %0d, actual %0d", want.left_col, l);
				errors++;
			end
			if (rt !== want.right_col) begin
				$error("right_col: expected %0d, actual %0d", want.right_col, rt);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DIM_W-1:0]     cfg_wdata;

	cbcb_pixel_if  pix_ch ();
	cbcb_bounds_if box_ch ();

	clear_border_crop_bounds u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pixel     (pix_ch),
		.bounds    (box_ch)
	);

	crop_predictor    sb;
	bit               burst;
	int               sent;
	logic [PIX_W-1:0] frame_base;
	int               box_r0;
	int               box_r1;
	int               box_c0;
	int               box_c1;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		pix_ch.valid = 1'b0;
		pix_ch.red = '0;
		pix_ch.green = '0;
		pix_ch.blue = '0;
		pix_ch.alpha = '0;
		box_ch.ready = 1'b0;
	end

	always #6 clk = ~clk;

	initial begin
		#30000000;
		$display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && box_ch.valid && box_ch.ready)
			sb.check_box(box_ch.status, box_ch.top_row, box_ch.bottom_row,
				box_ch.left_col, box_ch.right_col);
	end

	// result side: random stalls with occasional calm stretches
	initial begin
		int stall;
		int calm;
		calm = 0;
		@(posedge arst_n);
		forever begin
			if (calm > 0) begin
				stall = 0;
				calm--;
			end else begin
				stall = $urandom_range(0, 12);
				if ($urandom_range(0, 7) == 0) calm = $urandom_range(4, 16);
			end
			if (stall > 0) begin
				box_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			box_ch.ready <= 1'b1;
			do @(posedge clk); while (!box_ch.valid);
		end
	end

	task automatic push_pixel(logic [PIX_W-1:0] p);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			pix_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.red <= p[7:0];
		pix_ch.green <= p[15:8];
		pix_ch.blue <= p[23:16];
		pix_ch.alpha <= p[31:24];
		do @(posedge clk); while (!pix_ch.ready);
		sb.take_pixel(p[7:0], p[15:8], p[23:16], p[31:24]);
		sent++;
	endtask

	// drain: stop sending, wait for every owed box, then cover the pipeline
	task automatic settle();
		pix_ch.valid <= 1'b0;
		while (sb.owed_boxes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
		settle();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [DIM_W-1:0] pick_dim();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;
		if (r < 8) return DIM_W'($urandom_range(1, 6));
		return DIM_W'($urandom_range(7, 20));
	endfunction

	task automatic write_random_reg(logic [CFG_IDX_W-1:0] idx);
		if (idx == REG_ALPHA)
			write_reg(idx, DIM_W'($urandom_range(0, 8191)));
		else
			write_reg(idx, pick_dim());
	endtask

	task automatic new_scene();
		int w;
		int h;
		w = sb.span(sb.width_reg);
		h = sb.span(sb.height_reg);
		case ($urandom_range(0, 5))
			0: frame_base = '0;
			1: frame_base = '1;
			default: frame_base = $urandom;
		endcase
		box_r0 = $urandom_range(0, h - 1);
		box_r1 = $urandom_range(box_r0, h - 1);
		box_c0 = $urandom_range(0, w - 1);
		box_c1 = $urandom_range(box_c0, w - 1);
	endtask

	function automatic logic [PIX_W-1:0] make_pixel(scene_t kind, int row, int col, int w, int h);
		logic [PIX_W-1:0] p;
		bit               corner;
		if (row == 0 && col == 0) return frame_base;
		p = frame_base;
		case (kind)
			FR_NOISE: if ($urandom_range(0, 1)) p = $urandom;
			FR_BOX: begin
				corner = (row == box_r0 || row == box_r1) && (col == box_c0 || col == box_c1);
				if (corner)
					p = frame_base ^ (32'd1 << $urandom_range(0, 23));
				else if (row >= box_r0 && row <= box_r1 && col >= box_c0 && col <= box_c1
						&& $urandom_range(0, 3) != 0)
					p = frame_base ^ $urandom;
			end
			FR_BORDER: begin
				if (row == 0 || row == h - 1 || col == 0 || col == w - 1)
					p = frame_base ^ (32'd1 << $urandom_range(0, 31));
			end
			FR_ALPHA: p[31:24] = 8'($urandom);
			default: p = frame_base;
		endcase
		return p;
	endfunction

	task automatic run_pixels(scene_t kind, int from, int upto);
		int w;
		int h;
		w = sb.span(sb.width_reg);
		h = sb.span(sb.height_reg);
		for (int i = from; i < upto; i++)
			push_pixel(make_pixel(kind, i / w, i % w, w, h));
	endtask

	function automatic int frame_size();
		return sb.span(sb.width_reg) * sb.span(sb.height_reg);
	endfunction

	initial begin
		scene_t kind;
		int     total;
		int     cut;
		int     pick;
		int     waited;
		sb = new();
		sb.power_on();
		burst = 0;
		sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: 1x1 frames at both color extremes
		frame_base = '0;
		run_pixels(FR_CLEAR, 0, 1);
		frame_base = '1;
		run_pixels(FR_CLEAR, 0, 1);
		write_reg(REG_WIDTH, 13'd2);
		write_reg(REG_HEIGHT, 13'd2);
		new_scene();
		box_r0 = 0;
		box_r1 = 1;
		box_c0 = 1;
		box_c1 = 1;
		run_pixels(FR_BOX, 0, 4);
		new_scene();
		run_pixels(FR_BORDER, 0, 4);
		// alpha-only differences are clear when alpha is off
		write_reg(REG_ALPHA, 13'd0);
		new_scene();
		run_pixels(FR_ALPHA, 0, 4);
		write_reg(REG_ALPHA, 13'd1);
		new_scene();
		run_pixels(FR_ALPHA, 0, 4);
		write_reg(REG_WIDTH, 13'd0);
		write_reg(REG_HEIGHT, 13'd0);
		new_scene();
		run_pixels(FR_NOISE, 0, 1);
		// ignored index keeps the frame going; a real write aborts it
		write_reg(REG_WIDTH, 13'd3);
		write_reg(REG_HEIGHT, 13'd2);
		new_scene();
		run_pixels(FR_BORDER, 0, 2);
		write_reg(REG_NONE, 13'h1FFF);
		run_pixels(FR_BORDER, 2, 6);
		new_scene();
		run_pixels(FR_NOISE, 0, 3);
		write_reg(REG_ALPHA, 13'd1);
		new_scene();
		run_pixels(FR_BORDER, 0, 6);

		// oversize width: a long row stays open, then an abort
		burst = 1;
		write_reg(REG_WIDTH, 13'h1FFF);
		write_reg(REG_HEIGHT, 13'd1);
		new_scene();
		run_pixels(FR_NOISE, 0, 64);
		write_reg(REG_WIDTH, 13'd4);

		while (sent < 1600) begin
			if ($urandom_range(0, 4) == 0) begin
				for (int r = 0; r < 3; r++)
					if ($urandom_range(0, 1)) write_random_reg(CFG_IDX_W'(r));
			end
			burst = ($urandom_range(0, 3) == 0);
			kind = scene_t'($urandom_range(0, 4));
			new_scene();
			total = frame_size();
			pick = $urandom_range(0, 19);
			if (pick == 0 && total > 1) begin
				cut = $urandom_range(1, total - 1);
				run_pixels(kind, 0, cut);
				write_random_reg(CFG_IDX_W'($urandom_range(0, 2)));
			end else if (pick == 1 && total > 1) begin
				cut = $urandom_range(1, total - 1);
				run_pixels(kind, 0, cut);
				write_reg(REG_NONE, DIM_W'($urandom_range(0, 8191)));
				run_pixels(kind, cut, total);
			end else begin
				run_pixels(kind, 0, total);
				if (pick == 2) settle();
			end
		end

		pix_ch.valid <= 1'b0;
		waited = 0;
		while (sb.owed_boxes.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.owed_boxes.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
